// File: design/stamped_lru_memo_cache_assert.svh
// ----------------------------------------------------------------------------
// stamped_lru_memo_cache assertion macros
// shared concurrent assertion forms clocked on aclk, off while in reset
// ----------------------------------------------------------------------------
`ifndef STAMPED_LRU_MEMO_CACHE_ASSERT_SVH
`define STAMPED_LRU_MEMO_CACHE_ASSERT_SVH

// same-cycle implication
`define SLMC_ASSERT_SAME(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |-> (prop)) \
        else $error(msg);

// next-cycle implication
`define SLMC_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond) |=> (prop)) \
        else $error(msg);

`endif

// File: design/slmc_pkg.sv
// ----------------------------------------------------------------------------
// slmc_pkg
// shared types and constants of the stamped lru memo cache
// ----------------------------------------------------------------------------
package slmc_pkg;

    localparam int ENTRIES     = 16;
    localparam int IDX_W       = $clog2(ENTRIES);
    localparam int KEY_W       = 64;
    localparam int SIZE_W      = 48;
    localparam int TIME_W      = 64;
    localparam int PAYLOAD_W   = 32;
    localparam int TICK_W      = 64;
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [0:0] {
        REQ_LOOKUP = 1'b0,
        REQ_STORE  = 1'b1
    } req_kind_t;

    typedef struct packed {
        req_kind_t              kind;
        logic [KEY_W-1:0]       key;
        logic [SIZE_W-1:0]      size;
        logic [TIME_W-1:0]      stime;
        logic [PAYLOAD_W-1:0]   payload;
    } req_t;

    typedef struct packed {
        logic                   hit;
        logic [PAYLOAD_W-1:0]   payload;
        logic                   evicted;
        logic [KEY_W-1:0]       evicted_key;
    } rsp_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DECIDE,
        BK_SCAN,
        BK_EVICT
    } bk_state_t;

endpackage

// File: design/slmc_front.sv
// ----------------------------------------------------------------------------
// slmc_front
// input stage: takes request transactions, classifies them and feeds the queue
// ----------------------------------------------------------------------------
module slmc_front (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [slmc_pkg::KEY_W-1:0]          s_entry_key,
    input  logic [slmc_pkg::SIZE_W-1:0]         s_stamp_size,
    input  logic signed [slmc_pkg::TIME_W-1:0]  s_stamp_time,
    input  logic [slmc_pkg::PAYLOAD_W-1:0]      s_payload_in,
    output logic                                push,
    output slmc_pkg::req_t                      push_item,
    input  slmc_pkg::q_status_t                 q_status
);

    logic            hold_valid_reg, hold_valid_next;
    slmc_pkg::req_t  hold_item_reg, hold_item_next;
    logic            accept;
    logic            pushed;

    assign pushed    = hold_valid_reg && !q_status.full;
    assign s_ready   = !hold_valid_reg || !q_status.full;
    assign accept    = s_valid && s_ready;
    assign push      = hold_valid_reg;
    assign push_item = hold_item_reg;

    always_comb begin
        hold_item_next         = hold_item_reg;
        hold_valid_next        = hold_valid_reg;
        if (accept) begin
            hold_item_next.kind    = s_req_type ? slmc_pkg::REQ_STORE : slmc_pkg::REQ_LOOKUP;
            hold_item_next.key     = s_entry_key;
            hold_item_next.size    = s_stamp_size;
            hold_item_next.stime   = $unsigned(s_stamp_time);
            hold_item_next.payload = s_payload_in;
            hold_valid_next        = 1'b1;
        end else if (pushed) begin
            hold_valid_next        = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else begin
            hold_valid_reg <= hold_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hold_item_reg <= hold_item_next;
    end

endmodule

// File: design/slmc_queue.sv
// ----------------------------------------------------------------------------
// slmc_queue
// short request fifo between the front and back parts
// ----------------------------------------------------------------------------
module slmc_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push,
    input  slmc_pkg::req_t       push_item,
    input  logic                 pop,
    output slmc_pkg::req_t       head,
    output slmc_pkg::q_status_t  q_status
);

    slmc_pkg::req_t                   mem [slmc_pkg::QUEUE_DEPTH];
    logic [slmc_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [slmc_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [slmc_pkg::QCNT_W-1:0]      count_reg, count_next;
    logic                             do_push;
    logic                             do_pop;

    assign q_status.empty = (count_reg == '0);
    assign q_status.full  = (count_reg == slmc_pkg::QCNT_W'(slmc_pkg::QUEUE_DEPTH));
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && !q_status.empty;
    assign head           = mem[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == slmc_pkg::QPTR_W'(slmc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + slmc_pkg::QPTR_W'(1);
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == slmc_pkg::QPTR_W'(slmc_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + slmc_pkg::QPTR_W'(1);
        end
        if (do_push && !do_pop) begin
            count_next = count_reg + slmc_pkg::QCNT_W'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - slmc_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_item;
        end
    end

endmodule

// File: design/slmc_back.sv
// ----------------------------------------------------------------------------
// slmc_back
// cache engine: slot storage, key match, lru victim scan and result register
// ----------------------------------------------------------------------------
module slmc_back (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  slmc_pkg::req_t                   head,
    input  slmc_pkg::q_status_t              q_status,
    output logic                             pop,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic                             m_hit,
    output logic [slmc_pkg::PAYLOAD_W-1:0]   m_payload_out,
    output logic                             m_evicted,
    output logic [slmc_pkg::KEY_W-1:0]       m_evicted_key
);

    localparam int N = slmc_pkg::ENTRIES;
    localparam int IW = slmc_pkg::IDX_W;
    localparam int TW = slmc_pkg::TICK_W;

    slmc_pkg::bk_state_t                state_reg, state_next;

    logic                               slot_valid_reg [N];
    logic [slmc_pkg::KEY_W-1:0]         slot_key_reg [N];
    logic [slmc_pkg::SIZE_W-1:0]        slot_size_reg [N];
    logic [slmc_pkg::TIME_W-1:0]        slot_time_reg [N];
    logic [slmc_pkg::PAYLOAD_W-1:0]     slot_payload_reg [N];
    logic [TW-1:0]                      slot_last_use_reg [N];
    logic [TW-1:0]                      use_clock_reg, use_clock_next;

    slmc_pkg::req_t                     cur_reg;
    logic                               match_found_reg, match_found_next;
    logic [IW-1:0]                      match_idx_reg, match_idx_next;
    logic                               free_found_reg, free_found_next;
    logic [IW-1:0]                      free_idx_reg, free_idx_next;
    logic [IW-1:0]                      scan_idx_reg, scan_idx_next;
    logic [IW-1:0]                      best_idx_reg, best_idx_next;
    logic [TW-1:0]                      best_tick_reg, best_tick_next;
    logic                               out_valid_reg, out_valid_next;
    slmc_pkg::rsp_t                     out_reg, out_next;

    logic                               out_free;
    logic                               stamp_ok;
    logic                               wr_tick;
    logic                               wr_fill;
    logic [IW-1:0]                      wr_idx;
    logic                               load_out;
    slmc_pkg::rsp_t                     rsp;

    assign out_free = !out_valid_reg || m_ready;
    assign stamp_ok = (slot_size_reg[match_idx_reg] == cur_reg.size)
                   && (slot_time_reg[match_idx_reg] == cur_reg.stime);

    // key match and first free slot against the queue head
    always_comb begin
        match_found_next = 1'b0;
        match_idx_next   = '0;
        free_found_next  = 1'b0;
        free_idx_next    = '0;
        for (int i = N - 1; i >= 0; i--) begin
            if (slot_valid_reg[i] && (slot_key_reg[i] == head.key)) begin
                match_found_next = 1'b1;
                match_idx_next   = IW'(i);
            end
            if (!slot_valid_reg[i]) begin
                free_found_next  = 1'b1;
                free_idx_next    = IW'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            slmc_pkg::BK_IDLE: begin
                if (!q_status.empty) begin
                    state_next = slmc_pkg::BK_DECIDE;
                end
            end
            slmc_pkg::BK_DECIDE: begin
                if (cur_reg.kind == slmc_pkg::REQ_STORE && !match_found_reg
                    && !free_found_reg) begin
                    state_next = slmc_pkg::BK_SCAN;
                end else if (out_free) begin
                    state_next = slmc_pkg::BK_IDLE;
                end
            end
            slmc_pkg::BK_SCAN: begin
                if (scan_idx_reg == IW'(N - 1)) begin
                    state_next = slmc_pkg::BK_EVICT;
                end
            end
            slmc_pkg::BK_EVICT: begin
                if (out_free) begin
                    state_next = slmc_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = slmc_pkg::BK_IDLE;
            end
        endcase
    end

    // outputs and datapath control
    always_comb begin
        pop            = 1'b0;
        wr_tick        = 1'b0;
        wr_fill        = 1'b0;
        wr_idx         = match_idx_reg;
        load_out       = 1'b0;
        rsp            = '0;
        scan_idx_next  = scan_idx_reg;
        best_idx_next  = best_idx_reg;
        best_tick_next = best_tick_reg;
        case (state_reg)
            slmc_pkg::BK_IDLE: begin
                pop = !q_status.empty;
            end
            slmc_pkg::BK_DECIDE: begin
                if (cur_reg.kind == slmc_pkg::REQ_LOOKUP) begin
                    if (out_free) begin
                        load_out = 1'b1;
                        if (match_found_reg && stamp_ok) begin
                            wr_tick     = 1'b1;
                            rsp.hit     = 1'b1;
                            rsp.payload = slot_payload_reg[match_idx_reg];
                        end
                    end
                end else if (match_found_reg || free_found_reg) begin
                    wr_idx = match_found_reg ? match_idx_reg : free_idx_reg;
                    if (out_free) begin
                        load_out = 1'b1;
                        wr_tick  = 1'b1;
                        wr_fill  = 1'b1;
                    end
                end else begin
                    scan_idx_next  = '0;
                    best_idx_next  = '0;
                    best_tick_next = '1;
                end
            end
            slmc_pkg::BK_SCAN: begin
                if (slot_last_use_reg[scan_idx_reg] < best_tick_reg) begin
                    best_idx_next  = scan_idx_reg;
                    best_tick_next = slot_last_use_reg[scan_idx_reg];
                end
                if (scan_idx_reg != IW'(N - 1)) begin
                    scan_idx_next = scan_idx_reg + IW'(1);
                end
            end
            slmc_pkg::BK_EVICT: begin
                wr_idx = best_idx_reg;
                if (out_free) begin
                    load_out        = 1'b1;
                    wr_tick         = 1'b1;
                    wr_fill         = 1'b1;
                    rsp.evicted     = 1'b1;
                    rsp.evicted_key = slot_key_reg[best_idx_reg];
                end
            end
            default: begin
                pop = 1'b0;
            end
        endcase
    end

    always_comb begin
        use_clock_next = wr_tick ? use_clock_reg + TW'(1) : use_clock_reg;
        out_next       = load_out ? rsp : out_reg;
        if (load_out) begin
            out_valid_next = 1'b1;
        end else if (m_ready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= slmc_pkg::BK_IDLE;
            use_clock_reg <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < N; i++) begin
                slot_valid_reg[i] <= 1'b0;
            end
        end else begin
            state_reg     <= state_next;
            use_clock_reg <= use_clock_next;
            out_valid_reg <= out_valid_next;
            if (wr_fill) begin
                slot_valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg         <= head;
            match_found_reg <= match_found_next;
            match_idx_reg   <= match_idx_next;
            free_found_reg  <= free_found_next;
            free_idx_reg    <= free_idx_next;
        end
        scan_idx_reg  <= scan_idx_next;
        best_idx_reg  <= best_idx_next;
        best_tick_reg <= best_tick_next;
        out_reg       <= out_next;
        if (wr_fill) begin
            slot_key_reg[wr_idx]     <= cur_reg.key;
            slot_size_reg[wr_idx]    <= cur_reg.size;
            slot_time_reg[wr_idx]    <= cur_reg.stime;
            slot_payload_reg[wr_idx] <= cur_reg.payload;
        end
        if (wr_tick) begin
            slot_last_use_reg[wr_idx] <= use_clock_next;
        end
    end

    assign m_valid       = out_valid_reg;
    assign m_hit         = out_reg.hit;
    assign m_payload_out = out_reg.payload;
    assign m_evicted     = out_reg.evicted;
    assign m_evicted_key = out_reg.evicted_key;

endmodule

// File: design/stamped_lru_memo_cache.sv
// ----------------------------------------------------------------------------
// stamped_lru_memo_cache
// fully associative memo table with stamp check and lru replacement
// ----------------------------------------------------------------------------
// usage:
//   s_ channel carries one request transaction: a lookup (s_req_type 0) or a
//   store (s_req_type 1) with key, size/time stamp and payload handle.
//   m_ channel returns exactly one result transaction per request, in order:
//   hit and payload on a lookup, evicted flag and evicted key on a store.
//   a request passes the input register, the queue, the match registers and
//   the result register; a store into a full table with a new key scans all
//   slot ticks, one slot per cycle, before it evicts.
//   the two-step back engine (match, then decide and write) takes a new
//   request only once it is back in idle; evicting stores also scan and evict.
//   a two-entry request queue sits between the input stage and the engine,
//   so requests keep flowing in while a result waits in the output register.
//   reset (aresetn low, synchronous) empties the queue, clears all slots and
//   the use clock. when m_ready stays low the result holds, the engine stops
//   and back pressure reaches s_ready once the queue and input stage fill.
// ----------------------------------------------------------------------------
`include "stamped_lru_memo_cache_assert.svh"

module stamped_lru_memo_cache (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  logic                                s_req_type,
    input  logic [slmc_pkg::KEY_W-1:0]          s_entry_key,
    input  logic [slmc_pkg::SIZE_W-1:0]         s_stamp_size,
    input  logic signed [slmc_pkg::TIME_W-1:0]  s_stamp_time,
    input  logic [slmc_pkg::PAYLOAD_W-1:0]      s_payload_in,
    output logic                                m_valid,
    input  logic                                m_ready,
    output logic                                m_hit,
    output logic [slmc_pkg::PAYLOAD_W-1:0]      m_payload_out,
    output logic                                m_evicted,
    output logic [slmc_pkg::KEY_W-1:0]          m_evicted_key
);

    logic                  q_push;
    logic                  q_pop;
    slmc_pkg::req_t        q_push_item;
    slmc_pkg::req_t        q_head;
    slmc_pkg::q_status_t   q_status;

    slmc_front u_front (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_req_type   (s_req_type),
        .s_entry_key  (s_entry_key),
        .s_stamp_size (s_stamp_size),
        .s_stamp_time (s_stamp_time),
        .s_payload_in (s_payload_in),
        .push         (q_push),
        .push_item    (q_push_item),
        .q_status     (q_status)
    );

    slmc_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_item (q_push_item),
        .pop       (q_pop),
        .head      (q_head),
        .q_status  (q_status)
    );

    slmc_back u_back (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .head          (q_head),
        .q_status      (q_status),
        .pop           (q_pop),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_payload_out (m_payload_out),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

    `SLMC_ASSERT_SAME(a_hit_evict_excl, m_valid, !(m_hit && m_evicted), "hit and evicted both set")
    `SLMC_ASSERT_SAME(a_miss_zero_payload, m_valid && !m_hit, m_payload_out == '0, "payload on miss")
    `SLMC_ASSERT_SAME(a_no_evict_zero_key, m_valid && !m_evicted, m_evicted_key == '0, "stray key")
    `SLMC_ASSERT_NEXT(a_queue_holds, q_status.full && !q_pop, q_status.full, "queue lost an entry")

endmodule

// File: verif/stamped_lru_memo_cache_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// stamped_lru_memo_cache_tb
// request and result transactions checked field by field against a table model
// ----------------------------------------------------------------------------
module stamped_lru_memo_cache_tb;

    localparam int CYCLE_LIMIT = 400000;
    localparam int POOL_KEYS   = 24;

    logic                           aclk;
    logic                           aresetn       = 1'b0;
    logic                           s_valid       = 1'b0;
    logic                           s_ready;
    logic                           s_req_type    = 1'b0;
    logic [slmc_pkg::KEY_W-1:0]     s_entry_key   = '0;
    logic [slmc_pkg::SIZE_W-1:0]    s_stamp_size  = '0;
    logic [slmc_pkg::TIME_W-1:0]    s_stamp_time  = '0;
    logic [slmc_pkg::PAYLOAD_W-1:0] s_payload_in  = '0;
    logic                           m_valid;
    logic                           m_ready       = 1'b0;
    logic                           m_hit;
    logic [slmc_pkg::PAYLOAD_W-1:0] m_payload_out;
    logic                           m_evicted;
    logic [slmc_pkg::KEY_W-1:0]     m_evicted_key;

    bit                             idle_on = 1'b1;
    int                             cycle_count = 0;
    int                             mismatch_count = 0;
    slmc_pkg::rsp_t                 expected_results[$];

    // table model
    bit                             slot_used   [slmc_pkg::ENTRIES];
    bit [slmc_pkg::KEY_W-1:0]       slot_tag    [slmc_pkg::ENTRIES];
    bit [slmc_pkg::SIZE_W-1:0]      slot_sz     [slmc_pkg::ENTRIES];
    bit [slmc_pkg::TIME_W-1:0]      slot_tm     [slmc_pkg::ENTRIES];
    bit [slmc_pkg::PAYLOAD_W-1:0]   slot_handle [slmc_pkg::ENTRIES];
    bit [slmc_pkg::TICK_W-1:0]      slot_tick   [slmc_pkg::ENTRIES];
    bit [slmc_pkg::TICK_W-1:0]      tick_now = '0;

    stamped_lru_memo_cache dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_req_type    (s_req_type),
        .s_entry_key   (s_entry_key),
        .s_stamp_size  (s_stamp_size),
        .s_stamp_time  (s_stamp_time),
        .s_payload_in  (s_payload_in),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_hit         (m_hit),
        .m_payload_out (m_payload_out),
        .m_evicted     (m_evicted),
        .m_evicted_key (m_evicted_key)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
    end

    function automatic slmc_pkg::rsp_t cache_access(
        slmc_pkg::req_kind_t kind,
        logic [slmc_pkg::KEY_W-1:0] key,
        logic [slmc_pkg::SIZE_W-1:0] size,
        logic [slmc_pkg::TIME_W-1:0] stime,
        logic [slmc_pkg::PAYLOAD_W-1:0] handle);
        slmc_pkg::rsp_t r;
        int             slot;
        r    = '0;
        slot = -1;
        for (int i = 0; i < slmc_pkg::ENTRIES; i++) begin
            if (slot < 0 && slot_used[i] && slot_tag[i] == key) begin
                slot = i;
            end
        end
        if (kind == slmc_pkg::REQ_LOOKUP) begin
            if (slot >= 0 && slot_sz[slot] == size && slot_tm[slot] == stime) begin
                tick_now        = tick_now + 1'b1;
                slot_tick[slot] = tick_now;
                r.hit           = 1'b1;
                r.payload       = slot_handle[slot];
            end
            return r;
        end
        for (int i = 0; i < slmc_pkg::ENTRIES; i++) begin
            if (slot < 0 && !slot_used[i]) begin
                slot = i;
            end
        end
        if (slot < 0) begin
            slot = 0;
            for (int i = 1; i < slmc_pkg::ENTRIES; i++) begin
                if (slot_tick[i] < slot_tick[slot]) begin
                    slot = i;
                end
            end
            r.evicted     = 1'b1;
            r.evicted_key = slot_tag[slot];
        end
        tick_now          = tick_now + 1'b1;
        slot_used[slot]   = 1'b1;
        slot_tag[slot]    = key;
        slot_sz[slot]     = size;
        slot_tm[slot]     = stime;
        slot_handle[slot] = handle;
        slot_tick[slot]   = tick_now;
        return r;
    endfunction

    task automatic send_request(input slmc_pkg::req_kind_t kind,
                                input logic [slmc_pkg::KEY_W-1:0] key,
                                input logic [slmc_pkg::SIZE_W-1:0] size,
                                input logic [slmc_pkg::TIME_W-1:0] stime,
                                input logic [slmc_pkg::PAYLOAD_W-1:0] handle);
        int gap;
        gap = 0;
        if (idle_on && $urandom_range(0, 99) < 25) begin
            gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid      <= 1'b1;
        s_req_type   <= kind;
        s_entry_key  <= key;
        s_stamp_size <= size;
        s_stamp_time <= stime;
        s_payload_in <= handle;
        do @(posedge aclk); while (!s_ready);
        expected_results.push_back(cache_access(kind, key, size, stime, handle));
    endtask

    // result transaction checker
    always @(posedge aclk) begin
        slmc_pkg::rsp_t exp_r;
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                mismatch_count <= mismatch_count + 1;
                if (mismatch_count < 10) begin
                    $display("tb: extra result at %0d: hit=%0b pay=%h ev=%0b key=%h",
                             cycle_count, m_hit, m_payload_out, m_evicted, m_evicted_key);
                end
            end else begin
                exp_r = expected_results.pop_front();
                if (m_hit !== exp_r.hit || m_payload_out !== exp_r.payload ||
                    m_evicted !== exp_r.evicted || m_evicted_key !== exp_r.evicted_key) begin
                    mismatch_count <= mismatch_count + 1;
                    if (mismatch_count < 10) begin
                        $display("tb: mismatch at %0d: exp hit=%0b pay=%h ev=%0b key=%h",
                                 cycle_count, exp_r.hit, exp_r.payload, exp_r.evicted,
                                 exp_r.evicted_key);
                        $display("tb:                 got hit=%0b pay=%h ev=%0b key=%h",
                                 m_hit, m_payload_out, m_evicted, m_evicted_key);
                    end
                end
            end
        end
        m_ready <= !(idle_on && $urandom_range(0, 99) < 25);
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    task automatic test_hits_and_stamps();
        logic [slmc_pkg::KEY_W-1:0]  key_lo;
        logic [slmc_pkg::KEY_W-1:0]  key_hi;
        logic [slmc_pkg::TIME_W-1:0] time_min;
        logic [slmc_pkg::TIME_W-1:0] time_max;
        key_lo   = '0;
        key_hi   = '1;
        time_min = {1'b1, {(slmc_pkg::TIME_W-1){1'b0}}};
        time_max = {1'b0, {(slmc_pkg::TIME_W-1){1'b1}}};
        send_request(slmc_pkg::REQ_LOOKUP, key_lo, '0, '0, '0);
        send_request(slmc_pkg::REQ_STORE,  key_lo, '0, '0, '0);
        send_request(slmc_pkg::REQ_STORE,  key_hi, '1, time_min, '1);
        send_request(slmc_pkg::REQ_LOOKUP, key_lo, '0, '0, '1);
        send_request(slmc_pkg::REQ_LOOKUP, key_hi, '1, time_min, '0);
        send_request(slmc_pkg::REQ_LOOKUP, key_hi, '1 - 1'b1, time_min, '0);
        send_request(slmc_pkg::REQ_LOOKUP, key_hi, '1, time_max, '0);
        send_request(slmc_pkg::REQ_STORE,  key_hi, '1, time_max, 32'h5a5a_a5a5);
        send_request(slmc_pkg::REQ_LOOKUP, key_hi, '1, time_min, '0);
        send_request(slmc_pkg::REQ_LOOKUP, key_hi, '1, time_max, '0);
    endtask

    task automatic test_fill_and_evict();
        for (int i = 2; i < slmc_pkg::ENTRIES; i++) begin
            send_request(slmc_pkg::REQ_STORE, 64'h1000 + i, 48'(i), 64'(-i), 32'h100 + i);
        end
        send_request(slmc_pkg::REQ_LOOKUP, '0, '0, '0, '0);
        send_request(slmc_pkg::REQ_STORE,  64'hdead_beef_0000_0001, 48'h1, 64'h1, 32'h77);
        send_request(slmc_pkg::REQ_STORE,  64'hdead_beef_0000_0002, 48'h2, 64'h2, 32'h78);
        send_request(slmc_pkg::REQ_LOOKUP, '1, '1,
                     {1'b0, {(slmc_pkg::TIME_W-1){1'b1}}}, '0);
    endtask

    task automatic test_lru_working_set(input int count);
        logic [slmc_pkg::KEY_W-1:0]  pool_key  [POOL_KEYS];
        logic [slmc_pkg::SIZE_W-1:0] pool_size [POOL_KEYS];
        logic [slmc_pkg::TIME_W-1:0] pool_time [POOL_KEYS];
        int                          k;
        int                          roll;
        for (int i = 0; i < POOL_KEYS; i++) begin
            pool_key[i]  = rand64();
            pool_size[i] = slmc_pkg::SIZE_W'(rand64());
            pool_time[i] = rand64();
        end
        for (int n = 0; n < count; n++) begin
            k    = $urandom_range(0, POOL_KEYS - 1);
            roll = $urandom_range(0, 99);
            if (roll < 45) begin
                send_request(slmc_pkg::REQ_LOOKUP, pool_key[k], pool_size[k], pool_time[k],
                             $urandom);
            end else if (roll < 50) begin
                send_request(slmc_pkg::REQ_LOOKUP, pool_key[k],
                             pool_size[k] ^ (slmc_pkg::SIZE_W'(1)
                                 << $urandom_range(0, slmc_pkg::SIZE_W - 1)),
                             pool_time[k], $urandom);
            end else if (roll < 55) begin
                send_request(slmc_pkg::REQ_LOOKUP, pool_key[k], pool_size[k],
                             pool_time[k] ^ (slmc_pkg::TIME_W'(1)
                                 << $urandom_range(0, slmc_pkg::TIME_W - 1)),
                             $urandom);
            end else if (roll < 60) begin
                send_request(slmc_pkg::REQ_LOOKUP, rand64(), pool_size[k], pool_time[k],
                             $urandom);
            end else if (roll < 80) begin
                send_request(slmc_pkg::REQ_STORE, pool_key[k], pool_size[k], pool_time[k],
                             $urandom);
            end else begin
                pool_size[k] = slmc_pkg::SIZE_W'(rand64());
                pool_time[k] = rand64();
                send_request(slmc_pkg::REQ_STORE, pool_key[k], pool_size[k], pool_time[k],
                             $urandom);
            end
        end
    endtask

    task automatic test_random_noise(input int count);
        for (int n = 0; n < count; n++) begin
            send_request(slmc_pkg::req_kind_t'($urandom_range(0, 1)), rand64(),
                         slmc_pkg::SIZE_W'(rand64()), rand64(), $urandom);
        end
    endtask

    task automatic test_stream_without_gaps(input int count);
        idle_on = 1'b0;
        test_lru_working_set(count);
        idle_on = 1'b1;
    endtask

    initial begin
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        test_hits_and_stamps();
        test_fill_and_evict();
        test_lru_working_set(1000);
        test_random_noise(200);
        test_stream_without_gaps(150);
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4 * slmc_pkg::ENTRIES) @(posedge aclk);
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) @(posedge aclk);
        $display("tb: timeout after %0d cycles", cycle_count);
        $display("tb: failure");
        $finish;
    end

endmodule

// File: stamped_lru_memo_cache.f
+incdir+design
design/slmc_pkg.sv
design/slmc_front.sv
design/slmc_queue.sv
design/slmc_back.sv
design/stamped_lru_memo_cache.sv
verif/stamped_lru_memo_cache_tb.sv
